### design/cbd_pkg.sv
// Shared types and constants for the compass bearing pipeline.
// Holds the CORDIC arctangent table and the fixed-point formats; no dependencies.
`default_nettype none

package cbd_pkg;

  // Coordinate and difference widths.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned MAG_W = COORD_W;

  // CORDIC datapath: magnitude pre-shifted by PRE_SHIFT, with headroom for the
  // CORDIC gain and a sign bit.
  localparam int unsigned PRE_SHIFT = 16;
  localparam int unsigned XY_W = MAG_W + PRE_SHIFT + 3;
  localparam int unsigned CORDIC_STAGES = 20;

  // Angles are degrees with ANG_FRAC fractional bits.
  localparam int unsigned ANG_FRAC = 24;
  localparam int unsigned Z_W = 33;
  localparam int unsigned TOT_W = 33;
  localparam int unsigned BEARING_W = TOT_W - ANG_FRAC;

  // Stream word widths.
  localparam int unsigned S_TDATA_W = 4 * COORD_W;
  localparam int unsigned M_TDATA_W = 16;

  // atan(2^-i) in degrees, scaled by 2^ANG_FRAC and rounded to nearest.
  localparam logic signed [Z_W-1:0] ATAN_TAB [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  // How the first-quadrant angle is formed from the CORDIC result.
  typedef enum logic [2:0] {
    MODE_ZERO,       // no east difference: due north or south
    MODE_NINETY,     // no up difference: due east or west
    MODE_FORTYFIVE,  // equal magnitudes
    MODE_DIRECT,     // east smaller than up: angle is the CORDIC result
    MODE_COMPL       // east larger than up: angle is 90 less the CORDIC result
  } mode_e;

  // Side information that travels alongside the CORDIC stages.
  typedef struct packed {
    logic  east_neg;
    logic  up_neg;
    mode_e mode;
  } meta_t;

endpackage

`default_nettype wire

### design/cbd_prep.sv
// Input stage of the bearing pipeline: differences, magnitudes, octant fold.
// Depends on cbd_pkg.
`default_nettype none

module cbd_prep (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic signed [cbd_pkg::COORD_W-1:0] start_x_i,
  input  wire logic signed [cbd_pkg::COORD_W-1:0] start_y_i,
  input  wire logic signed [cbd_pkg::COORD_W-1:0] end_x_i,
  input  wire logic signed [cbd_pkg::COORD_W-1:0] end_y_i,
  output logic                                   valid_o,
  output logic signed [cbd_pkg::XY_W-1:0]        x_o,
  output logic signed [cbd_pkg::XY_W-1:0]        y_o,
  output cbd_pkg::meta_t                         meta_o
);
  import cbd_pkg::*;

  logic signed [DIFF_W-1:0] east;
  logic signed [DIFF_W-1:0] up;
  logic [DIFF_W-1:0]        east_abs;
  logic [DIFF_W-1:0]        up_abs;
  logic [MAG_W-1:0]         mag_a;
  logic [MAG_W-1:0]         mag_b;
  logic [MAG_W-1:0]         hi;
  logic [MAG_W-1:0]         lo;
  meta_t                    meta_d;
  logic                     valid_q;
  logic signed [XY_W-1:0]   x_q;
  logic signed [XY_W-1:0]   y_q;
  meta_t                    meta_q;

  always_comb begin
    east     = DIFF_W'(end_x_i) - DIFF_W'(start_x_i);
    up       = DIFF_W'(start_y_i) - DIFF_W'(end_y_i);
    east_abs = east[DIFF_W-1] ? DIFF_W'(-east) : DIFF_W'(east);
    up_abs   = up[DIFF_W-1] ? DIFF_W'(-up) : DIFF_W'(up);
    // A magnitude of 17-bit differences never exceeds 65535.
    mag_a    = east_abs[MAG_W-1:0];
    mag_b    = up_abs[MAG_W-1:0];

    meta_d.east_neg = east[DIFF_W-1];
    meta_d.up_neg   = up[DIFF_W-1];
    if (mag_a == '0) begin
      meta_d.mode = MODE_ZERO;
    end else if (mag_b == '0) begin
      meta_d.mode = MODE_NINETY;
    end else if (mag_a == mag_b) begin
      meta_d.mode = MODE_FORTYFIVE;
    end else if (mag_a < mag_b) begin
      meta_d.mode = MODE_DIRECT;
    end else begin
      meta_d.mode = MODE_COMPL;
    end

    if (mag_a < mag_b) begin
      hi = mag_b;
      lo = mag_a;
    end else begin
      hi = mag_a;
      lo = mag_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= $signed({3'b000, hi, PRE_SHIFT'(0)});
      y_q    <= $signed({3'b000, lo, PRE_SHIFT'(0)});
      meta_q <= meta_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign meta_o  = meta_q;

endmodule

`default_nettype wire

### design/cbd_cordic.sv
// Unrolled CORDIC vectoring pipeline, one micro-rotation per register stage.
// Depends on cbd_pkg for widths, the stage count and the arctangent table.
`default_nettype none

module cbd_cordic (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic signed [cbd_pkg::XY_W-1:0] x_i,
  input  wire logic signed [cbd_pkg::XY_W-1:0] y_i,
  input  wire cbd_pkg::meta_t             meta_i,
  output logic                            valid_o,
  output logic signed [cbd_pkg::Z_W-1:0]  z_o,
  output cbd_pkg::meta_t                  meta_o
);
  import cbd_pkg::*;

  logic                   valid_w [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] x_w     [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] y_w     [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  z_w     [CORDIC_STAGES+1];
  meta_t                  meta_w  [CORDIC_STAGES+1];

  assign valid_w[0] = valid_i;
  assign x_w[0]     = x_i;
  assign y_w[0]     = y_i;
  assign z_w[0]     = '0;
  assign meta_w[0]  = meta_i;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic                   valid_q;
    logic signed [XY_W-1:0] x_q;
    logic signed [XY_W-1:0] y_q;
    logic signed [Z_W-1:0]  z_q;
    meta_t                  meta_q;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    // Arithmetic shifts floor, as the rotation expects.
    assign xs = x_w[s] >>> s;
    assign ys = y_w[s] >>> s;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= valid_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_w[s][XY_W-1]) begin
          x_q <= x_w[s] + ys;
          y_q <= y_w[s] - xs;
          z_q <= z_w[s] + ATAN_TAB[s];
        end else begin
          x_q <= x_w[s] - ys;
          y_q <= y_w[s] + xs;
          z_q <= z_w[s] - ATAN_TAB[s];
        end
        meta_q <= meta_w[s];
      end
    end

    assign valid_w[s+1] = valid_q;
    assign x_w[s+1]     = x_q;
    assign y_w[s+1]     = y_q;
    assign z_w[s+1]     = z_q;
    assign meta_w[s+1]  = meta_q;
  end

  assign valid_o = valid_w[CORDIC_STAGES];
  assign z_o     = z_w[CORDIC_STAGES];
  assign meta_o  = meta_w[CORDIC_STAGES];

endmodule

`default_nettype wire

### design/cbd_post.sv
// Output stage: clamps the octant angle, unfolds octant and quadrant, floors.
// Holds the output register of the stream. Depends on cbd_pkg.
`default_nettype none

module cbd_post (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic signed [cbd_pkg::Z_W-1:0] z_i,
  input  wire cbd_pkg::meta_t             meta_i,
  output logic                            valid_o,
  output logic [cbd_pkg::BEARING_W-1:0]   bearing_o
);
  import cbd_pkg::*;

  localparam logic [TOT_W-1:0] DEG45  = TOT_W'(45) << ANG_FRAC;
  localparam logic [TOT_W-1:0] DEG90  = TOT_W'(90) << ANG_FRAC;
  localparam logic [TOT_W-1:0] DEG180 = TOT_W'(180) << ANG_FRAC;
  localparam logic [TOT_W-1:0] DEG360 = TOT_W'(360) << ANG_FRAC;

  logic [TOT_W-1:0]     z_clamp;
  logic [TOT_W-1:0]     phi;
  logic [TOT_W-1:0]     total;
  logic [TOT_W-1:0]     total_wrap;
  logic [BEARING_W-1:0] bearing_d;
  logic                 valid_q;
  logic [BEARING_W-1:0] bearing_q;

  always_comb begin
    if (z_i[Z_W-1]) begin
      z_clamp = '0;
    end else if (TOT_W'($unsigned(z_i)) > DEG45) begin
      z_clamp = DEG45;
    end else begin
      z_clamp = TOT_W'($unsigned(z_i));
    end

    case (meta_i.mode)
      MODE_ZERO:      phi = '0;
      MODE_NINETY:    phi = DEG90;
      MODE_FORTYFIVE: phi = DEG45;
      MODE_DIRECT:    phi = z_clamp;
      MODE_COMPL:     phi = DEG90 - z_clamp;
      default:        phi = '0;
    endcase

    case ({meta_i.east_neg, meta_i.up_neg})
      2'b00:   total = phi;
      2'b01:   total = DEG180 - phi;
      2'b11:   total = DEG180 + phi;
      default: total = DEG360 - phi;
    endcase

    // Due north approached from the west side lands on 360 and wraps to 0.
    total_wrap = (total >= DEG360) ? total - DEG360 : total;
    bearing_d  = total_wrap[TOT_W-1:ANG_FRAC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bearing_q <= bearing_d;
    end
  end

  assign valid_o   = valid_q;
  assign bearing_o = bearing_q;

endmodule

`default_nettype wire

### design/compass_bearing_degrees_top.sv
// Top level of the compass bearing block: input fold, CORDIC pipeline, output stage.
// Depends on cbd_pkg, cbd_prep, cbd_cordic and cbd_post.
//
//   Channel   Direction  Payload (tdata, lowest bits first)
//   s_axis    in         start_x, start_y, end_x, end_y (16 bits each)
//   m_axis    out        bearing_deg (9 bits), zero filled to 16 bits
//
// One word enters per cycle and one result word leaves per cycle when the
// downstream side keeps m_axis_tready high. A word passes through one register
// for the octant fold, one per CORDIC stage (twenty micro-rotations) and the
// output register. Reset clears only the valid bits of every stage; payload
// registers are left as they are. When a result waits in the output register
// and m_axis_tready is low, the whole pipeline holds and s_axis_tready falls,
// so no word is lost or repeated. Every stage moves together, so bubbles
// inside the pipeline are kept as they are and leave in order with the words.
`default_nettype none

module compass_bearing_degrees_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [15:0] start_x, [31:16] start_y, [47:32] end_x, [63:48] end_y
  input  wire logic [cbd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [8:0] bearing_deg, [15:9] zero
  output logic [cbd_pkg::M_TDATA_W-1:0]         m_axis_tdata
);
  import cbd_pkg::*;

  logic                   pipe_en;
  logic                   prep_valid;
  logic signed [XY_W-1:0] prep_x;
  logic signed [XY_W-1:0] prep_y;
  meta_t                  prep_meta;
  logic                   cordic_valid;
  logic signed [Z_W-1:0]  cordic_z;
  meta_t                  cordic_meta;
  logic                   out_valid;
  logic [BEARING_W-1:0]   bearing;

  // The pipeline advances whenever the output register is empty or being
  // taken this cycle; every stage moves together.
  assign pipe_en       = !out_valid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  cbd_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .valid_i   (s_axis_tvalid),
    .start_x_i ($signed(s_axis_tdata[COORD_W-1:0])),
    .start_y_i ($signed(s_axis_tdata[2*COORD_W-1:COORD_W])),
    .end_x_i   ($signed(s_axis_tdata[3*COORD_W-1:2*COORD_W])),
    .end_y_i   ($signed(s_axis_tdata[4*COORD_W-1:3*COORD_W])),
    .valid_o   (prep_valid),
    .x_o       (prep_x),
    .y_o       (prep_y),
    .meta_o    (prep_meta)
  );

  cbd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (prep_valid),
    .x_i     (prep_x),
    .y_i     (prep_y),
    .meta_i  (prep_meta),
    .valid_o (cordic_valid),
    .z_o     (cordic_z),
    .meta_o  (cordic_meta)
  );

  cbd_post u_post (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .valid_i   (cordic_valid),
    .z_i       (cordic_z),
    .meta_i    (cordic_meta),
    .valid_o   (out_valid),
    .bearing_o (bearing)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(M_TDATA_W - BEARING_W)'(0), bearing};

endmodule

`default_nettype wire

### design/cbd_checker.sv
// Port-level checks for the compass bearing block, bound to the top level.
// Depends on cbd_pkg for the stream widths.
`default_nettype none

module cbd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [cbd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [cbd_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import cbd_pkg::*;

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // Every bearing is a whole degree below 360 with zero fill above.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:0] < 9'd360) && (m_axis_tdata[15:9] == 7'd0))
    else $error("bearing out of range");

  // The input side is held off exactly while a result waits unaccepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output backpressure");

  // Reset empties the pipeline, so no result word is offered in the cycle
  // after an edge at which reset was held.
  assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result word offered straight after reset");

endmodule

bind compass_bearing_degrees_top cbd_checker u_cbd_checker (.*);

`default_nettype wire
